// File: rtl/hpr_pkg.sv
// ----------------------------------------------------------------------------
// hpr_pkg: shared types and constants
// Config register map, datapath widths and fixed-point constants of the
// heading PI rudder controller.
// ----------------------------------------------------------------------------
`default_nettype none

package hpr_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INTEGRAL_GAIN = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_PERIOD = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RUDDER_MAX    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RUDDER_MIN    = 3'd4;

  // shared multiplier: signed A x signed B
  localparam int MUL_AW = 34;
  localparam int MUL_BW = 24;
  localparam int PROD_W = MUL_AW + MUL_BW;

  // angles in 1/64 degree
  localparam logic signed [17:0] HALF_TURN     = 18'sd11520;
  localparam logic signed [17:0] NEG_HALF_TURN = -18'sd11520;
  localparam logic signed [17:0] FULL_TURN     = 18'sd23040;

  // 180 degrees in 2^-14 degree units
  localparam logic signed [MUL_AW-1:0] MAP_DEN = 34'sd2949120;

  // floor(q / 45) via offset and reciprocal: q is saturated to a span that
  // still lands outside any legal rudder limit, then shifted non-negative
  localparam logic signed [42:0] Q_MAX   = 43'sd737280;
  localparam logic signed [42:0] Q_MIN   = -43'sd737325;
  localparam logic signed [21:0] DIV_OFS = 22'sd737325;
  localparam logic signed [MUL_BW-1:0] RECIP_45 = 24'sd2982617;  // ceil(2^27/45)
  localparam logic signed [17:0] QUOT_OFS = 18'sd16385;

  typedef struct packed {
    logic [15:0]        prop_gain;
    logic [15:0]        integral_gain;
    logic [15:0]        sample_period;
    logic [13:0]        rudder_max;
    logic signed [14:0] rudder_min;
  } hpr_cfg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ERR,
    ST_MUL_P,
    ST_MUL_KE,
    ST_MUL_INC,
    ST_INTEG,
    ST_ACT,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_MUL_OFS,
    ST_ACC,
    ST_SAT,
    ST_MUL_DIV,
    ST_CLAMP
  } hpr_state_e;

endpackage

`default_nettype wire

// File: rtl/hpr_in_if.sv
// ----------------------------------------------------------------------------
// hpr_in_if: sample channel
// Valid/ready channel carrying one heading sample per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface hpr_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] desired_heading;
  logic signed [15:0] measured_heading;

  modport source (output valid, desired_heading, measured_heading, input ready);
  modport sink   (input valid, desired_heading, measured_heading, output ready);
endinterface

`default_nettype wire

// File: rtl/hpr_out_if.sv
// ----------------------------------------------------------------------------
// hpr_out_if: rudder command channel
// Valid/ready channel carrying one rudder angle per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface hpr_out_if;
  logic               valid;
  logic               ready;
  logic signed [14:0] rudder_angle;

  modport source (output valid, rudder_angle, input ready);
  modport sink   (input valid, rudder_angle, output ready);
endinterface

`default_nettype wire

// File: rtl/heading_pi_rudder_controller.sv
// ----------------------------------------------------------------------------
// heading_pi_rudder_controller: PI heading loop to rudder angle
// Wraps heading error, runs a saturating PI law and maps the action onto
// a clamped rudder command.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  carries one sample per beat: desired and measured heading, signed
//          1/64 degree. out_ch returns one rudder angle per sample.
//   cfg_*  writes gains, sample period and rudder limits; write only while
//          no sample is in flight. Indexes beyond the map are ignored.
// Timing:
//   A sample is taken only in idle, so a new sample waits until the last
//   one has left its clamp step. The sequencer feeds one registered 34x24
//   multiplier seven times (P term, two for the integral term, two partial
//   products of the mapping, the mapping offset, divide by 45).
// Reset:
//   Registers return to their defaults and the integrator clears to zero.
// Stall:
//   A result waits in the output register; a new sample is still accepted
//   and runs up to its last step, where it waits until the register frees.
// ----------------------------------------------------------------------------
`default_nettype none

module heading_pi_rudder_controller
  import hpr_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  hpr_in_if.sink                     in_ch,
  hpr_out_if.source                  out_ch,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i
);

  function automatic logic signed [17:0] wrap_angle(input logic signed [17:0] x);
    logic signed [17:0] y;
    y = x;
    if (y > HALF_TURN)     y = y - FULL_TURN;
    if (y < NEG_HALF_TURN) y = y + FULL_TURN;
    return y;
  endfunction

  hpr_cfg_t cfg;

  hpr_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  hpr_state_e state_q, state_d;

  logic signed [15:0]       des_q, meas_q, e_q;
  logic signed [32:0]       p_q;
  logic signed [39:0]       sum_q, sum_d;
  logic signed [40:0]       act_q;
  logic signed [17:0]       k_q;
  logic signed [59:0]       acc_q;
  logic [20:0]              u_q;
  logic                     out_valid_q;
  logic signed [14:0]       out_data_q;

  logic                     mul_en;
  logic signed [MUL_AW-1:0] mul_a;
  logic signed [MUL_BW-1:0] mul_b;
  logic signed [PROD_W-1:0] prod;

  hpr_mul u_mul (
    .clk_i  (clk_i),
    .en_i   (mul_en),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  // product sign-extended to the accumulator width
  logic signed [59:0] prod_x;
  assign prod_x = {{(60-PROD_W){prod[PROD_W-1]}}, prod};

  logic signed [17:0] rmax18, rmin18;
  assign rmax18 = $signed({4'b0, cfg.rudder_max});
  assign rmin18 = {{3{cfg.rudder_min[14]}}, cfg.rudder_min};

  // error wrap
  logic signed [17:0] d_wr, diff, e_wr;
  always_comb begin
    d_wr = wrap_angle({{2{des_q[15]}}, des_q});
    diff = d_wr - {{2{meas_q[15]}}, meas_q};
    e_wr = wrap_angle(diff);
  end

  // integrator update, saturating at 40 bits
  logic signed [31:0] inc;
  logic signed [40:0] sum_new;
  always_comb begin
    inc     = prod[47:16];
    sum_new = {sum_q[39], sum_q} + {{9{inc[31]}}, inc};
    if (sum_new[40] != sum_new[39]) begin
      sum_d = sum_new[40] ? {1'b1, 39'b0} : {1'b0, {39{1'b1}}};
    end else begin
      sum_d = sum_new[39:0];
    end
  end

  // slope of the mapping: 2*limit - rudder_max
  logic signed [17:0] lim, k_new;
  always_comb begin
    lim   = (e_q > 16'sd0) ? rmax18 : rmin18;
    k_new = (lim <<< 1) - rmax18;
  end

  // floor(num / 2^17), saturated, then offset for the reciprocal divide
  logic signed [42:0] q_raw, q_sat;
  logic signed [21:0] u_sum;
  always_comb begin
    q_raw = acc_q[59:17];
    q_sat = q_raw;
    if (q_raw > Q_MAX) q_sat = Q_MAX;
    if (q_raw < Q_MIN) q_sat = Q_MIN;
    u_sum = q_sat[21:0] + DIV_OFS;
  end

  // quotient back to a signed angle, then clamp
  logic [16:0]        quot;
  logic signed [17:0] r_raw, r_clp;
  always_comb begin
    quot  = prod[43:27];
    r_raw = $signed({1'b0, quot}) - QUOT_OFS;
    r_clp = r_raw;
    if (r_clp > rmax18) r_clp = rmax18;
    if (r_clp < rmin18) r_clp = rmin18;
  end

  logic out_free;
  assign out_free = !out_valid_q || out_ch.ready;

  // sequencer: next state and multiplier operands
  always_comb begin
    state_d = state_q;
    mul_en  = 1'b0;
    mul_a   = '0;
    mul_b   = '0;
    case (state_q)
      ST_IDLE:    if (in_ch.valid) state_d = ST_ERR;
      ST_ERR:     state_d = ST_MUL_P;
      ST_MUL_P: begin
        mul_en  = 1'b1;
        mul_a   = {{(MUL_AW-16){e_q[15]}}, e_q};
        mul_b   = $signed({{(MUL_BW-16){1'b0}}, cfg.prop_gain});
        state_d = ST_MUL_KE;
      end
      ST_MUL_KE: begin
        mul_en  = 1'b1;
        mul_a   = {{(MUL_AW-16){e_q[15]}}, e_q};
        mul_b   = $signed({{(MUL_BW-16){1'b0}}, cfg.integral_gain});
        state_d = ST_MUL_INC;
      end
      ST_MUL_INC: begin
        mul_en  = 1'b1;
        mul_a   = prod[MUL_AW-1:0];
        mul_b   = $signed({{(MUL_BW-16){1'b0}}, cfg.sample_period});
        state_d = ST_INTEG;
      end
      ST_INTEG:   state_d = ST_ACT;
      ST_ACT:     state_d = ST_MUL_LO;
      ST_MUL_LO: begin
        // low 24 bits of the action, zero extended
        mul_en  = 1'b1;
        mul_a   = $signed({{(MUL_AW-24){1'b0}}, act_q[23:0]});
        mul_b   = {{(MUL_BW-18){k_q[17]}}, k_q};
        state_d = ST_MUL_HI;
      end
      ST_MUL_HI: begin
        mul_en  = 1'b1;
        mul_a   = {{(MUL_AW-17){act_q[40]}}, act_q[40:24]};
        mul_b   = {{(MUL_BW-18){k_q[17]}}, k_q};
        state_d = ST_MUL_OFS;
      end
      ST_MUL_OFS: begin
        // (rudder_max + 1) * Q folds both constant terms of the numerator
        mul_en  = 1'b1;
        mul_a   = MAP_DEN;
        mul_b   = $signed({{(MUL_BW-14){1'b0}}, cfg.rudder_max} + 24'd1);
        state_d = ST_ACC;
      end
      ST_ACC:     state_d = ST_SAT;
      ST_SAT:     state_d = ST_MUL_DIV;
      ST_MUL_DIV: begin
        mul_en  = 1'b1;
        mul_a   = $signed({{(MUL_AW-21){1'b0}}, u_q});
        mul_b   = RECIP_45;
        state_d = ST_CLAMP;
      end
      ST_CLAMP:   if (out_free) state_d = ST_IDLE;
      default:    state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (state_q == ST_INTEG) sum_q <= sum_d;
      if (state_q == ST_CLAMP && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        des_q  <= in_ch.desired_heading;
        meas_q <= in_ch.measured_heading;
      end
      ST_ERR:     e_q   <= e_wr[15:0];
      ST_MUL_KE:  p_q   <= prod[32:0];
      ST_ACT: begin
        act_q <= {sum_q[39], sum_q} + {{8{p_q[32]}}, p_q};
        k_q   <= k_new;
      end
      ST_MUL_HI:  acc_q <= prod_x;
      ST_MUL_OFS: acc_q <= acc_q + (prod_x <<< 24);
      ST_ACC:     acc_q <= acc_q + prod_x;
      ST_SAT:     u_q   <= u_sum[20:0];
      ST_CLAMP:   if (out_free) out_data_q <= r_clp[14:0];
      default: ;
    endcase
  end

  assign in_ch.ready         = (state_q == ST_IDLE);
  assign out_ch.valid        = out_valid_q;
  assign out_ch.rudder_angle = out_data_q;

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_ch.valid && in_ch.ready) |=> (state_q == ST_ERR))
    else $error("accepted sample did not start the sequence");

  a_integ_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_INTEG) |=> $stable(sum_q))
    else $error("integrator changed outside its update step");

  a_load_from_clamp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == ST_CLAMP))
    else $error("result loaded outside the clamp step");

  a_in_limits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (rmin18 <= rmax18) && $stable(cfg)) |->
      ($signed({{3{out_data_q[14]}}, out_data_q}) <= rmax18 &&
       $signed({{3{out_data_q[14]}}, out_data_q}) >= rmin18))
    else $error("rudder command outside limits");

endmodule

`default_nettype wire

// File: rtl/hpr_cfg.sv
// ----------------------------------------------------------------------------
// hpr_cfg: configuration registers
// Write-only register file for gains, sample period and rudder limits.
// ----------------------------------------------------------------------------
`default_nettype none

module hpr_cfg
  import hpr_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  output hpr_cfg_t                   cfg_o
);

  hpr_cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_PROP_GAIN:     cfg_d.prop_gain     = cfg_data_i;
        REG_INTEGRAL_GAIN: cfg_d.integral_gain = cfg_data_i;
        REG_SAMPLE_PERIOD: cfg_d.sample_period = cfg_data_i;
        REG_RUDDER_MAX:    cfg_d.rudder_max    = cfg_data_i[13:0];
        REG_RUDDER_MIN:    cfg_d.rudder_min    = $signed(cfg_data_i[14:0]);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.prop_gain     <= 16'd512;
      cfg_q.integral_gain <= 16'd256;
      cfg_q.sample_period <= 16'd13107;
      cfg_q.rudder_max    <= 14'd2880;
      cfg_q.rudder_min    <= -15'sd2880;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// File: rtl/hpr_mul.sv
// ----------------------------------------------------------------------------
// hpr_mul: shared multiplier
// Signed multiplier with a registered product, reused by every multiply step.
// ----------------------------------------------------------------------------
`default_nettype none

module hpr_mul
  import hpr_pkg::*;
(
  input  wire logic                     clk_i,
  input  wire logic                     en_i,
  input  wire logic signed [MUL_AW-1:0] a_i,
  input  wire logic signed [MUL_BW-1:0] b_i,
  output logic signed [PROD_W-1:0]      prod_o
);

  logic signed [PROD_W-1:0] prod_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= a_i * b_i;
    end
  end

  assign prod_o = prod_q;

endmodule

`default_nettype wire

// File: verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: heading PI rudder controller testbench
// Sends heading samples through the valid/ready input channel and predicts
// each rudder command with a cycle-free model of the wrap, PI law, mapping
// and clamp. A monitor compares every output beat with the oldest prediction.
// Covers field and register extremes, random samples under several register
// settings and idle patterns, a long output stall and an integrator limit.
// ----------------------------------------------------------------------------

module tb
  import hpr_pkg::*;
();

  localparam int  SRC_IDLE_PCT   = 6;
  localparam int  SNK_IDLE_PCT   = 69;
  localparam int  WATCHDOG_LIMIT = 2000;
  localparam int  HOLD_CYCLES    = 400;
  localparam int  SETTLE_CYCLES  = 4;
  localparam int  TAIL_CYCLES    = 20;
  localparam int  RAND_PER_CFG   = 12;

  localparam longint DEG180    = 11520;
  localparam longint DEG360    = 23040;
  localparam longint MAP_Q     = 2949120;  // 180 deg in 2^-14 deg units
  localparam longint INTEG_MAX = 64'sd549755813887;
  localparam longint INTEG_MIN = -64'sd549755813888;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  hpr_in_if  in_if();
  hpr_out_if out_if();

  heading_pi_rudder_controller uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_ch      (in_if),
    .out_ch     (out_if),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // predictor copy of the registers and the integrator, at reset values
  logic [15:0]        cfg_kp   = 16'd512;
  logic [15:0]        cfg_ki   = 16'd256;
  logic [15:0]        cfg_ts   = 16'd13107;
  logic [13:0]        cfg_rmax = 14'd2880;
  logic signed [14:0] cfg_rmin = -15'sd2880;
  longint             integ    = 0;

  logic signed [14:0] rudder_q[$];
  logic signed [14:0] exp_rudder;
  int                 mismatches  = 0;
  int                 idle_cycles = 0;
  int                 src_gap_pct = 0;
  int                 snk_stall_pct = 0;
  int                 hold_reqs   = 0;
  int                 hold_served = 0;
  int                 hold_left   = 0;

  function automatic longint floor_div(input longint n, input longint dv);
    if (n >= 0) return n / dv;
    return -((-n + dv - 1) / dv);
  endfunction

  // single wrap only: values beyond one extra turn stay out of range
  function automatic longint wrap_turn(input longint x);
    if (x > DEG180) x -= DEG360;
    if (x < -DEG180) x += DEG360;
    return x;
  endfunction

  function automatic logic signed [14:0] predict_rudder(input logic signed [15:0] des,
                                                        input logic signed [15:0] meas);
    longint d, e, p, inc, act, lim, num, r, rmax, rmin;
    d    = wrap_turn(longint'(des));
    e    = wrap_turn(d - longint'(meas));
    rmax = longint'(cfg_rmax);
    rmin = longint'(cfg_rmin);
    p    = longint'(cfg_kp) * e;
    inc  = floor_div(longint'(cfg_ki) * e * longint'(cfg_ts), 65536);
    integ = integ + inc;
    if (integ > INTEG_MAX) integ = INTEG_MAX;
    if (integ < INTEG_MIN) integ = INTEG_MIN;
    act = p + integ;
    // zero error takes the negative-side limit
    lim = (e > 0) ? rmax : rmin;
    num = rmax * MAP_Q + (2 * lim - rmax) * act + MAP_Q;
    r   = floor_div(num, 2 * MAP_Q);
    if (r > rmax) r = rmax;
    if (r < rmin) r = rmin;
    return $signed(r[14:0]);
  endfunction

  // input beats feed the predictor
  always @(posedge clk_i) begin
    if (rst_ni && in_if.valid && in_if.ready)
      rudder_q.push_back(predict_rudder(in_if.desired_heading, in_if.measured_heading));
  end

  // output beats against the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (rudder_q.size() == 0) begin
        $error("rudder_angle: no beat expected, actual %0d", out_if.rudder_angle);
        mismatches++;
      end else begin
        exp_rudder = rudder_q.pop_front();
        if (out_if.rudder_angle !== exp_rudder) begin
          $error("rudder_angle: expected %0d, actual %0d", exp_rudder, out_if.rudder_angle);
          mismatches++;
        end
      end
    end
  end

  // receiver: random stalls, or a long hold-off on request
  always @(posedge clk_i) begin
    if (hold_reqs != hold_served) begin
      hold_served   <= hold_reqs;
      hold_left     <= HOLD_CYCLES;
      out_if.ready  <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left    <= hold_left - 1;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= ($urandom_range(99) >= snk_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic send_sample(input int des, input int meas);
    while ($urandom_range(99) < src_gap_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid            <= 1'b1;
    in_if.desired_heading  <= 16'(des);
    in_if.measured_heading <= 16'(meas);
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
  endtask

  // block is idle once every predicted beat has come back
  task automatic drain_results();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (rudder_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    case (idx)
      REG_PROP_GAIN:     cfg_kp   = val;
      REG_INTEGRAL_GAIN: cfg_ki   = val;
      REG_SAMPLE_PERIOD: cfg_ts   = val;
      REG_RUDDER_MAX:    cfg_rmax = val[13:0];
      REG_RUDDER_MIN:    cfg_rmin = val[14:0];
      default: ;
    endcase
  endtask

  // all five registers, then a write to an unmapped index that must be ignored
  task automatic program_cfg(input logic [15:0] kp, input logic [15:0] ki,
                             input logic [15:0] ts, input logic [13:0] rmax,
                             input logic signed [14:0] rmin);
    write_reg(REG_PROP_GAIN, kp);
    write_reg(REG_INTEGRAL_GAIN, ki);
    write_reg(REG_SAMPLE_PERIOD, ts);
    write_reg(REG_RUDDER_MAX, 16'(rmax));
    write_reg(REG_RUDDER_MIN, 16'(rmin));
    write_reg(CFG_IDX_W'(REG_RUDDER_MIN + 1 + $urandom_range(2)), 16'($urandom));
    cfg_we_i <= 1'b0;
  endtask

  function automatic int pick_corner_heading();
    case ($urandom_range(6))
      0:       return -23040;
      1:       return -11521;
      2:       return -11520;
      3:       return 0;
      4:       return 11520;
      5:       return 11521;
      default: return 23040;
    endcase
  endfunction

  task automatic send_random_sample();
    int des, meas;
    des = int'($urandom_range(46080)) - 23040;
    case ($urandom_range(9))
      0, 1, 2, 3: meas = int'($urandom_range(46080)) - 23040;
      4, 5, 6, 7: begin
        // tracking close to course: small error around the wrap points too
        meas = des + int'($urandom_range(512)) - 256;
        if (meas > 23040) meas = 23040;
        if (meas < -23040) meas = -23040;
      end
      default: begin
        des  = pick_corner_heading();
        meas = pick_corner_heading();
      end
    endcase
    send_sample(des, meas);
  endtask

  task automatic apply_random_cfg();
    logic [15:0]        kp, ki, ts;
    logic [13:0]        rmax;
    logic signed [14:0] rmin;
    kp   = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(1024));
    ki   = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(512));
    ts   = 16'($urandom);
    rmax = 14'($urandom_range(11520));
    rmin = 15'(-int'($urandom_range(11520)));
    drain_results();
    program_cfg(kp, ki, ts, rmax, rmin);
  endtask

  task automatic test_reset_defaults();
    send_sample(0, 0);
    send_sample(2880, 0);
    send_sample(-2880, 0);
    send_sample(1, 0);
    send_sample(0, 1);
    send_sample(23040, -23040);
    send_sample(-23040, 23040);
    send_sample(23040, 23040);
    send_sample(-23040, -23040);
    send_sample(11520, -11520);
    send_sample(11520, 0);
    send_sample(0, 11520);
    send_sample(0, 11521);
    send_sample(11521, 0);
    send_sample(-11521, 0);
    send_sample(0, -23040);
  endtask

  task automatic test_register_extremes();
    drain_results();
    program_cfg(16'hFFFF, 16'hFFFF, 16'hFFFF, 14'd11520, -15'sd11520);
    send_sample(11520, 0);
    send_sample(-11520, 0);
    send_sample(0, 0);
    // equal limits at zero
    drain_results();
    program_cfg(16'd0, 16'd0, 16'd0, 14'd0, 15'sd0);
    send_sample(100, 0);
    send_sample(0, 100);
    drain_results();
    program_cfg(16'd256, 16'd0, 16'd0, 14'd0, -15'sd11520);
    send_sample(2880, 0);
    send_sample(-2880, 0);
    drain_results();
    program_cfg(16'd256, 16'd0, 16'd0, 14'd11520, 15'sd0);
    send_sample(2880, 0);
    send_sample(-2880, 0);
  endtask

  task automatic test_random_samples();
    for (int mode = 0; mode < 3; mode++) begin
      case (mode)
        0: begin src_gap_pct = SRC_IDLE_PCT; snk_stall_pct <= SNK_IDLE_PCT; end
        1: begin src_gap_pct = SNK_IDLE_PCT; snk_stall_pct <= SRC_IDLE_PCT; end
        default: begin src_gap_pct = 0; snk_stall_pct <= 0; end
      endcase
      for (int c = 0; c < 4; c++) begin
        apply_random_cfg();
        repeat (RAND_PER_CFG) send_random_sample();
      end
    end
  endtask

  // receiver holds off while samples keep coming, so the input stalls
  task automatic test_backpressure();
    drain_results();
    src_gap_pct = 0;
    snk_stall_pct <= 0;
    hold_reqs <= hold_reqs + 1;
    repeat (16) send_random_sample();
  endtask

  // drive the integrator into one limit, picked at random, with the largest
  // error the wrap allows, hold it there, then back it off the limit
  task automatic test_integrator_saturation();
    int     des, meas, back;
    longint target;
    drain_results();
    program_cfg(16'($urandom_range(1024)), 16'hFFFF, 16'hFFFF, 14'd11520, -15'sd11520);
    if ($urandom_range(1) == 0) begin
      des    = 11520;
      meas   = -32768;
      back   = 11520;
      target = INTEG_MAX;
    end else begin
      des    = -11520;
      meas   = 32767;
      back   = -11520;
      target = INTEG_MIN;
    end
    while (integ != target) send_sample(des, meas);
    repeat (8) send_sample(des, meas);
    repeat (8) send_sample(0, back);
  endtask

  initial begin
    rst_ni                 = 1'b0;
    in_if.valid            = 1'b0;
    in_if.desired_heading  = '0;
    in_if.measured_heading = '0;
    out_if.ready           = 1'b0;
    cfg_we_i               = 1'b0;
    cfg_idx_i              = '0;
    cfg_data_i             = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    src_gap_pct = SRC_IDLE_PCT;
    snk_stall_pct <= SNK_IDLE_PCT;
    test_reset_defaults();
    test_register_extremes();
    test_random_samples();
    test_backpressure();
    test_integrator_saturation();

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatches == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
